// ----- rtl/stg_pkg.sv -----
// ----------------------------------------------------------------------------
// Sine table generator package
// Field widths, register codes, reset values and fixed-point sine constants.
// ----------------------------------------------------------------------------
package stg_pkg;

   // stream fields
   localparam int IDX_W      = 8;
   localparam int VAL_W      = 16;
   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 24;

   // configuration registers
   localparam int PER_W      = 9;
   localparam int PEAK_W     = 16;
   localparam int PHASE_W    = 10;
   localparam int K_W        = PEAK_W - 1;
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_ADDR_W-1:0] CSR_PERIOD = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_PEAK   = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_PHASE  = 2'd2;

   localparam int PERIOD_RST     = 64;
   localparam int PEAK_RST       = 800;
   localparam int MAX_POINTS_DEF = 256;

   // index + phase
   localparam int SUM_W = 11;

   // fixed point: Q30 angle and sine
   localparam int FRAC_W = 30;
   localparam int T_W    = 30;
   localparam int ACC_W  = 32;
   localparam int MAG_W  = 31;
   localparam int S_W    = 31;
   localparam int HSTEPS = 5;

   localparam logic [S_W-1:0] S_ONE = 31'h4000_0000;

   // odd polynomial for sin(pi/2 * t), Q30
   localparam logic signed [ACC_W-1:0] SC1  = 32'sd1686629713;
   localparam logic signed [ACC_W-1:0] SC3  = 32'sd693598670;
   localparam logic signed [ACC_W-1:0] SC5  = 32'sd85569306;
   localparam logic signed [ACC_W-1:0] SC7  = 32'sd5026995;
   localparam logic signed [ACC_W-1:0] SC9  = 32'sd172272;
   localparam logic signed [ACC_W-1:0] SC11 = 32'sd3864;

   // per-request tag carried down the pipe
   typedef struct packed {
      logic [IDX_W-1:0] idx;
      logic             neg;    // second half of the period
      logic             zero;   // angle on a zero crossing
      logic             top;    // angle on a crest
   } stg_tag_type;

   localparam int TAG_W = IDX_W + 3;

   // coefficient added by Horner step i (1..5)
   function automatic logic signed [ACC_W-1:0] horner_coef(input int i);
      logic signed [ACC_W-1:0] c;
      case (i)
         1: c = SC9;
         2: c = -SC7;
         3: c = SC5;
         4: c = -SC3;
         5: c = SC1;
         default: c = '0;
      endcase
      return c;
   endfunction

endpackage

// ----- rtl/stg_div_cell.sv -----
// ----------------------------------------------------------------------------
// Restoring divider cell
// One quotient bit per cell: shift remainder/dividend left, conditionally
// subtract the divisor. Registered, with a side payload.
// ----------------------------------------------------------------------------
module stg_div_cell #(
   parameter int RW = 8,
   parameter int QW = 8,
   parameter int PW = 8
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          en,
   input  logic [RW-1:0] divisor,
   input  logic          in_vld,
   input  logic [RW-1:0] in_rem,
   input  logic [QW-1:0] in_dq,
   input  logic [PW-1:0] in_pay,
   output logic          out_vld,
   output logic [RW-1:0] out_rem,
   output logic [QW-1:0] out_dq,
   output logic [PW-1:0] out_pay
);

   logic [RW:0]   wide;
   logic [RW:0]   diff;
   logic          ge;
   logic [RW-1:0] rem_in;
   logic [QW-1:0] dq_in;

   logic          vld_ff;
   logic [RW-1:0] rem_ff;
   logic [QW-1:0] dq_ff;
   logic [PW-1:0] pay_ff;

   // remainder stays below the divisor, so the shifted value fits RW+1 bits
   assign wide   = {in_rem, in_dq[QW-1]};
   assign ge     = (wide >= {1'b0, divisor});
   assign diff   = wide - {1'b0, divisor};
   assign rem_in = ge ? diff[RW-1:0] : wide[RW-1:0];
   assign dq_in  = {in_dq[QW-2:0], ge};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (en) begin
         vld_ff <= in_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff <= rem_in;
         dq_ff  <= dq_in;
         pay_ff <= in_pay;
      end
   end

   assign out_vld = vld_ff;
   assign out_rem = rem_ff;
   assign out_dq  = dq_ff;
   assign out_pay = pay_ff;

endmodule

// ----- rtl/stg_horner_cell.sv -----
// ----------------------------------------------------------------------------
// Horner step cell
// out = COEF + (acc * op) in Q30, product truncated toward zero.
// Two stages: multiply, then sign and add.
// ----------------------------------------------------------------------------
module stg_horner_cell #(
   parameter logic signed [stg_pkg::ACC_W-1:0] COEF = '0,
   parameter int PW = 8
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             en,
   input  logic                             in_vld,
   input  logic signed [stg_pkg::ACC_W-1:0] in_acc,
   input  logic        [stg_pkg::T_W-1:0]   in_op,
   input  logic        [PW-1:0]             in_pay,
   output logic                             out_vld,
   output logic signed [stg_pkg::ACC_W-1:0] out_acc,
   output logic        [PW-1:0]             out_pay
);

   localparam int PROD_W = stg_pkg::MAG_W + stg_pkg::T_W;

   logic [stg_pkg::MAG_W-1:0]       mag;
   logic [PROD_W-1:0]               prod_in;
   logic [stg_pkg::MAG_W-1:0]       part;
   logic signed [stg_pkg::ACC_W-1:0] signed_part;
   logic signed [stg_pkg::ACC_W-1:0] acc_in;

   logic                             vld1_ff;
   logic [PROD_W-1:0]                prod_ff;
   logic                             neg_ff;
   logic [PW-1:0]                    pay1_ff;
   logic                             vld2_ff;
   logic signed [stg_pkg::ACC_W-1:0] acc_ff;
   logic [PW-1:0]                    pay2_ff;

   // sign-magnitude multiply; op is never negative
   assign mag     = in_acc[stg_pkg::ACC_W-1] ? stg_pkg::MAG_W'(-in_acc)
                                             : stg_pkg::MAG_W'(in_acc);
   assign prod_in = {{stg_pkg::T_W{1'b0}}, mag} * {{stg_pkg::MAG_W{1'b0}}, in_op};

   assign part        = prod_ff[PROD_W-1:stg_pkg::FRAC_W];
   assign signed_part = neg_ff ? -$signed({1'b0, part}) : $signed({1'b0, part});
   assign acc_in      = COEF + signed_part;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff <= 1'b0;
         vld2_ff <= 1'b0;
      end else if (en) begin
         vld1_ff <= in_vld;
         vld2_ff <= vld1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= prod_in;
         neg_ff  <= in_acc[stg_pkg::ACC_W-1];
         pay1_ff <= in_pay;
         acc_ff  <= acc_in;
         pay2_ff <= pay1_ff;
      end
   end

   assign out_vld = vld2_ff;
   assign out_acc = acc_ff;
   assign out_pay = pay2_ff;

endmodule

// ----- rtl/sine_table_generator.sv -----
// ----------------------------------------------------------------------------
// Sine table generator
// Returns one sample of a sampled sine wave for each requested sample index.
// ----------------------------------------------------------------------------
// Each request carries a sample index; the response echoes it together with
// floor(K*sin(pi*m/H) + K), m = (index + phase_offset) mod 2H, H = period/2,
// K = peak/2 (integer halves, so an odd period behaves as the even one below
// it; periods under 2 act as 2 and above MAX_POINTS as MAX_POINTS). The
// datapath is a row of registered cells: 11 restoring-divider cells reduce
// index+phase modulo 2H, one fold stage maps the angle into the first quadrant,
// 30 divider cells form t = r/H in Q30, seven two-stage Horner cells square t
// and evaluate the degree-11 sine polynomial, and three stages clamp, scale by
// K and round. Throughput is one request per clock while responses are taken.
// When the response is held off, the whole row stalls and a one-entry skid
// buffer still takes one more request. Registers (csr_addr): 0 period_points,
// 1 peak_value, 2 phase_offset; other indexes are ignored. Write them only
// while no request is in flight.
// ----------------------------------------------------------------------------
module sine_table_generator #(
   parameter int MAX_POINTS = stg_pkg::MAX_POINTS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   // request: [7:0] sample_index
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [stg_pkg::REQ_DATA_W-1:0] req_tdata,
   // response: [7:0] index_echo, [23:8] sample_value
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [stg_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // configuration write port
   input  logic                           csr_we,
   input  logic [stg_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  logic [stg_pkg::CSR_DATA_W-1:0] csr_wdata
);

   // period register holds at most 9 bits, so larger limits change nothing
   localparam int PER_LIM   = (1 << stg_pkg::PER_W) - 1;
   localparam int PER_MAX   = (MAX_POINTS < PER_LIM) ? MAX_POINTS : PER_LIM;
   localparam int H_MAX     = PER_MAX / 2;
   localparam int H_W       = $clog2(H_MAX + 1);
   localparam int D_W       = H_W + 1;
   localparam int H_RST     = ((stg_pkg::PERIOD_RST < PER_MAX) ?
                               stg_pkg::PERIOD_RST : PER_MAX) / 2;
   localparam int MOD_STEPS = stg_pkg::SUM_W;
   localparam int DIV_STEPS = stg_pkg::T_W;
   localparam int TAG_W     = stg_pkg::TAG_W;
   localparam int T_W       = stg_pkg::T_W;
   localparam int HP_W      = TAG_W + 2 * T_W;
   localparam int EPROD_W   = stg_pkg::K_W + stg_pkg::S_W;

   // ---------------------------------------------------------------- config
   logic [H_W-1:0]              h_ff;
   logic [stg_pkg::K_W-1:0]     k_ff;
   logic [stg_pkg::PHASE_W-1:0] phase_ff;
   logic [stg_pkg::PER_W-1:0]   per_wr;
   logic [stg_pkg::PER_W-1:0]   per_clamp;
   logic [H_W-1:0]              h_in;

   assign per_wr    = csr_wdata[stg_pkg::PER_W-1:0];
   assign per_clamp = (per_wr < stg_pkg::PER_W'(2)) ? stg_pkg::PER_W'(2) :
                      (per_wr > stg_pkg::PER_W'(PER_MAX)) ? stg_pkg::PER_W'(PER_MAX) :
                      per_wr;
   assign h_in      = H_W'(per_clamp >> 1);

   // H and K are kept already halved
   always_ff @(posedge clock) begin
      if (reset) begin
         h_ff     <= H_W'(H_RST);
         k_ff     <= stg_pkg::K_W'(stg_pkg::PEAK_RST / 2);
         phase_ff <= '0;
      end else if (csr_we) begin
         case (csr_addr)
            stg_pkg::CSR_PERIOD: h_ff     <= h_in;
            stg_pkg::CSR_PEAK:   k_ff     <= csr_wdata[stg_pkg::PEAK_W-1:1];
            stg_pkg::CSR_PHASE:  phase_ff <= csr_wdata[stg_pkg::PHASE_W-1:0];
            default: ;
         endcase
      end
   end

   // ------------------------------------------------------- skid and stall
   logic                      en;
   logic                      skid_vld_ff;
   logic [stg_pkg::IDX_W-1:0] skid_idx_ff;
   logic                      skid_vld_in;
   logic                      src_vld;
   logic [stg_pkg::IDX_W-1:0] src_idx;
   logic                      rsp_vld_ff;

   // whole row advances unless a response is stuck at the output
   assign en         = !rsp_vld_ff || rsp_tready;
   assign req_tready = !skid_vld_ff;
   assign src_vld    = skid_vld_ff || req_tvalid;
   assign src_idx    = skid_vld_ff ? skid_idx_ff : req_tdata[stg_pkg::IDX_W-1:0];

   always_comb begin
      skid_vld_in = skid_vld_ff;
      if (en) begin
         skid_vld_in = 1'b0;
      end else if (req_tvalid && !skid_vld_ff) begin
         skid_vld_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         skid_vld_ff <= 1'b0;
      end else begin
         skid_vld_ff <= skid_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (!en && !skid_vld_ff) begin
         skid_idx_ff <= req_tdata[stg_pkg::IDX_W-1:0];
      end
   end

   // ------------------------------------------------------ S0: index+phase
   logic                      s0_vld_ff;
   logic [stg_pkg::SUM_W-1:0] s0_sum_ff;
   logic [stg_pkg::IDX_W-1:0] s0_idx_ff;
   logic [stg_pkg::SUM_W-1:0] s0_sum_in;

   assign s0_sum_in = stg_pkg::SUM_W'(src_idx) + stg_pkg::SUM_W'(phase_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_vld_ff <= 1'b0;
      end else if (en) begin
         s0_vld_ff <= src_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s0_sum_ff <= s0_sum_in;
         s0_idx_ff <= src_idx;
      end
   end

   // ------------------------------------------------- modulo 2H cell chain
   logic [D_W-1:0]            d_div;
   logic                      m_vld [0:MOD_STEPS];
   logic [D_W-1:0]            m_rem [0:MOD_STEPS];
   logic [stg_pkg::SUM_W-1:0] m_dq  [0:MOD_STEPS];
   logic [stg_pkg::IDX_W-1:0] m_pay [0:MOD_STEPS];

   assign d_div    = {h_ff, 1'b0};
   assign m_vld[0] = s0_vld_ff;
   assign m_rem[0] = '0;
   assign m_dq[0]  = s0_sum_ff;
   assign m_pay[0] = s0_idx_ff;

   for (genvar i = 0; i < MOD_STEPS; i++) begin : g_mod
      stg_div_cell #(
         .RW (D_W),
         .QW (stg_pkg::SUM_W),
         .PW (stg_pkg::IDX_W)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .en      (en),
         .divisor (d_div),
         .in_vld  (m_vld[i]),
         .in_rem  (m_rem[i]),
         .in_dq   (m_dq[i]),
         .in_pay  (m_pay[i]),
         .out_vld (m_vld[i+1]),
         .out_rem (m_rem[i+1]),
         .out_dq  (m_dq[i+1]),
         .out_pay (m_pay[i+1])
      );
   end

   // ---------------------------------------------- fold to first quadrant
   logic [D_W-1:0]           m_val;
   logic                     f_neg;
   logic [D_W-1:0]           m_half;
   logic [D_W-1:0]           r_dbl;
   logic [D_W-1:0]           r_full;
   logic [H_W-1:0]           r_in;
   stg_pkg::stg_tag_type     f_tag_in;
   logic                     f_vld_ff;
   logic [H_W-1:0]           f_r_ff;
   stg_pkg::stg_tag_type     f_tag_ff;

   assign m_val  = m_rem[MOD_STEPS];
   assign f_neg  = (m_val >= {1'b0, h_ff});
   assign m_half = f_neg ? (m_val - {1'b0, h_ff}) : m_val;
   assign r_dbl  = {m_half[H_W-1:0], 1'b0};
   assign r_full = (r_dbl > {1'b0, h_ff}) ? ({h_ff, 1'b0} - r_dbl) : r_dbl;
   assign r_in   = r_full[H_W-1:0];

   always_comb begin
      f_tag_in.idx  = m_pay[MOD_STEPS];
      f_tag_in.neg  = f_neg;
      f_tag_in.zero = (r_in == '0);
      f_tag_in.top  = (r_in >= h_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f_vld_ff <= 1'b0;
      end else if (en) begin
         f_vld_ff <= m_vld[MOD_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         f_r_ff   <= r_in;
         f_tag_ff <= f_tag_in;
      end
   end

   // ---------------------------------------------- t = r/H, Q30, cell chain
   logic             d_vld [0:DIV_STEPS];
   logic [H_W-1:0]   d_rem [0:DIV_STEPS];
   logic [T_W-1:0]   d_dq  [0:DIV_STEPS];
   logic [TAG_W-1:0] d_pay [0:DIV_STEPS];

   // crest angle (r == H) is forced later; keep the divider in range
   assign d_vld[0] = f_vld_ff;
   assign d_rem[0] = f_tag_ff.top ? '0 : f_r_ff;
   assign d_dq[0]  = '0;
   assign d_pay[0] = f_tag_ff;

   for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
      stg_div_cell #(
         .RW (H_W),
         .QW (T_W),
         .PW (TAG_W)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .en      (en),
         .divisor (h_ff),
         .in_vld  (d_vld[i]),
         .in_rem  (d_rem[i]),
         .in_dq   (d_dq[i]),
         .in_pay  (d_pay[i]),
         .out_vld (d_vld[i+1]),
         .out_rem (d_rem[i+1]),
         .out_dq  (d_dq[i+1]),
         .out_pay (d_pay[i+1])
      );
   end

   // --------------------------------------------------- Horner cell chain
   logic [T_W-1:0]                   t_val;
   logic                             h0_vld;
   logic signed [stg_pkg::ACC_W-1:0] h0_acc;
   logic [TAG_W+T_W-1:0]             h0_pay;
   logic                             hv   [1:stg_pkg::HSTEPS+1];
   logic signed [stg_pkg::ACC_W-1:0] hacc [1:stg_pkg::HSTEPS+1];
   logic [HP_W-1:0]                  hpay [1:stg_pkg::HSTEPS+1];
   logic                             hf_vld;
   logic signed [stg_pkg::ACC_W-1:0] hf_acc;
   logic [TAG_W-1:0]                 hf_pay;

   assign t_val = d_dq[DIV_STEPS];

   // t squared
   stg_horner_cell #(
      .COEF ('0),
      .PW   (TAG_W + T_W)
   ) u_sq (
      .clock   (clock),
      .reset   (reset),
      .en      (en),
      .in_vld  (d_vld[DIV_STEPS]),
      .in_acc  ($signed({2'b00, t_val})),
      .in_op   (t_val),
      .in_pay  ({d_pay[DIV_STEPS], t_val}),
      .out_vld (h0_vld),
      .out_acc (h0_acc),
      .out_pay (h0_pay)
   );

   // payload layout: {tag, t, t2}
   assign hv[1]   = h0_vld;
   assign hacc[1] = -stg_pkg::SC11;
   assign hpay[1] = {h0_pay, h0_acc[T_W-1:0]};

   for (genvar i = 1; i <= stg_pkg::HSTEPS; i++) begin : g_horner
      stg_horner_cell #(
         .COEF (stg_pkg::horner_coef(i)),
         .PW   (HP_W)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .en      (en),
         .in_vld  (hv[i]),
         .in_acc  (hacc[i]),
         .in_op   (hpay[i][T_W-1:0]),
         .in_pay  (hpay[i]),
         .out_vld (hv[i+1]),
         .out_acc (hacc[i+1]),
         .out_pay (hpay[i+1])
      );
   end

   // final multiply by t
   stg_horner_cell #(
      .COEF ('0),
      .PW   (TAG_W)
   ) u_last (
      .clock   (clock),
      .reset   (reset),
      .en      (en),
      .in_vld  (hv[stg_pkg::HSTEPS+1]),
      .in_acc  (hacc[stg_pkg::HSTEPS+1]),
      .in_op   (hpay[stg_pkg::HSTEPS+1][2*T_W-1:T_W]),
      .in_pay  (hpay[stg_pkg::HSTEPS+1][HP_W-1:2*T_W]),
      .out_vld (hf_vld),
      .out_acc (hf_acc),
      .out_pay (hf_pay)
   );

   // ------------------------------------------ E1: clamp and exact points
   stg_pkg::stg_tag_type      hf_tag;
   logic [stg_pkg::S_W-1:0]   s_in;
   logic                      e1_vld_ff;
   logic [stg_pkg::S_W-1:0]   e1_s_ff;
   stg_pkg::stg_tag_type      e1_tag_ff;

   assign hf_tag = stg_pkg::stg_tag_type'(hf_pay);

   always_comb begin
      if (hf_tag.zero) begin
         s_in = '0;
      end else if (hf_tag.top) begin
         s_in = stg_pkg::S_ONE;
      end else if (hf_acc[stg_pkg::ACC_W-1]) begin
         s_in = '0;
      end else if (hf_acc > $signed({1'b0, stg_pkg::S_ONE})) begin
         s_in = stg_pkg::S_ONE;
      end else begin
         s_in = hf_acc[stg_pkg::S_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e1_vld_ff <= 1'b0;
      end else if (en) begin
         e1_vld_ff <= hf_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         e1_s_ff   <= s_in;
         e1_tag_ff <= hf_tag;
      end
   end

   // ----------------------------------------------------- E2: scale by K
   logic                      e2_vld_ff;
   logic [EPROD_W-1:0]        e2_prod_ff;
   logic                      e2_neg_ff;
   logic [stg_pkg::IDX_W-1:0] e2_idx_ff;
   logic [EPROD_W-1:0]        e2_prod_in;

   assign e2_prod_in = {{stg_pkg::S_W{1'b0}}, k_ff} * {{stg_pkg::K_W{1'b0}}, e1_s_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         e2_vld_ff <= 1'b0;
      end else if (en) begin
         e2_vld_ff <= e1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         e2_prod_ff <= e2_prod_in;
         e2_neg_ff  <= e1_tag_ff.neg;
         e2_idx_ff  <= e1_tag_ff.idx;
      end
   end

   // ---------------------------------------- E3: offset by K, output reg
   logic [stg_pkg::VAL_W-1:0] mag_floor;
   logic [stg_pkg::VAL_W-1:0] mag_ceil;
   logic [stg_pkg::VAL_W-1:0] val_in;
   logic [stg_pkg::VAL_W-1:0] rsp_val_ff;
   logic [stg_pkg::IDX_W-1:0] rsp_idx_ff;

   // floor on the positive half, ceiling on the negative half
   assign mag_floor = stg_pkg::VAL_W'(e2_prod_ff[EPROD_W-1:stg_pkg::FRAC_W]);
   assign mag_ceil  = mag_floor
                    + stg_pkg::VAL_W'(|e2_prod_ff[stg_pkg::FRAC_W-1:0]);
   assign val_in    = e2_neg_ff ? ({1'b0, k_ff} - mag_ceil) : ({1'b0, k_ff} + mag_floor);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (en) begin
         rsp_vld_ff <= e2_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_val_ff <= val_in;
         rsp_idx_ff <= e2_idx_ff;
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = {rsp_val_ff, rsp_idx_ff};

   // ------------------------------------------------------------ checks
   // a request offered during a stall lands in the skid buffer
   a_skid_fill: assert property (@(posedge clock) disable iff (reset)
      (!skid_vld_ff && !en && req_tvalid) |=> skid_vld_ff)
      else $error("skid buffer missed a request taken during a stall");

   // the skid entry drains as soon as the row moves again
   a_skid_drain: assert property (@(posedge clock) disable iff (reset)
      (skid_vld_ff && en) |=> !skid_vld_ff)
      else $error("skid buffer not drained when the pipeline advanced");

   // a stall never drops a request from the clamp stage (E1)
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (e1_vld_ff && !en) |=> (e1_vld_ff && $stable(e1_s_ff)))
      else $error("pipeline lost a request while stalled");

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sine table generator testbench
// Drives sample-index requests through the stream port under random bursts and
// response stalls, rewrites the registers between phases, and checks every
// response against a golden value or a bit-exact fixed-point sine model.
// ----------------------------------------------------------------------------
module testbench;

   localparam logic [stg_pkg::CSR_ADDR_W-1:0] CSR_UNUSED = 2'd3;  // no register here
   localparam int  RANDOM_PHASES   = 10;
   localparam int  ITEMS_PER_PHASE = 155;
   localparam int  HOLD_CYCLES     = 300;      // long response hold-off
   localparam int  DRAIN_CYCLES    = 80;       // idle tail after the last response
   localparam longint Q_ONE        = 64'd1073741824;

   typedef struct {
      logic [stg_pkg::IDX_W-1:0] idx;
      logic [stg_pkg::VAL_W-1:0] value;
   } sample_type;

   typedef enum logic [1:0] {ROW_CSR, ROW_REQ, ROW_REQ_CHK} row_kind_type;

   typedef struct {
      row_kind_type                   kind;
      logic [stg_pkg::CSR_ADDR_W-1:0] addr;
      logic [stg_pkg::CSR_DATA_W-1:0] data;
      logic [stg_pkg::IDX_W-1:0]      idx;
      logic [stg_pkg::VAL_W-1:0]      golden;
   } stim_row_type;

   logic                           clock;
   logic                           reset;
   logic                           req_tvalid;
   logic                           req_tready;
   logic [stg_pkg::REQ_DATA_W-1:0] req_tdata;   // [7:0] sample_index
   logic                           rsp_tvalid;
   logic                           rsp_tready;
   logic [stg_pkg::RSP_DATA_W-1:0] rsp_tdata;   // [7:0] index_echo, [23:8] sample_value
   logic                           csr_we;
   logic [stg_pkg::CSR_ADDR_W-1:0] csr_addr;
   logic [stg_pkg::CSR_DATA_W-1:0] csr_wdata;

   // shadow copy of the registers, only changed while the pipe is empty
   logic [stg_pkg::PER_W-1:0]   period_cfg;
   logic [stg_pkg::PEAK_W-1:0]  peak_cfg;
   logic [stg_pkg::PHASE_W-1:0] phase_cfg;

   sample_type   pending_samples[$];
   stim_row_type stim_rows[$];
   int           fail_count;
   int           burst_left;
   int           hold_asked;
   int           hold_served;

   sine_table_generator uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // run limit: far above the slowest legal run
   initial begin
      #2_000_000;
      $display("Verification failed");
      $finish;
   end

   // ------------------------------------------------------------------------
   // Fixed-point sine model
   // ------------------------------------------------------------------------

   // Q30 product, truncated toward zero
   function automatic longint q30_mul(input longint a, input longint b);
      longint unsigned ua, ub, p;
      ua = (a < 0) ? -a : a;
      ub = (b < 0) ? -b : b;
      p  = (ua * ub) >> 30;
      return ((a < 0) != (b < 0)) ? -longint'(p) : longint'(p);
   endfunction

   // sin(pi/2 * r/h) in Q30 for 0 <= r <= h
   function automatic longint quarter_wave(input int unsigned r, input int unsigned h);
      longint unsigned num;
      longint t, t2, acc;
      if (r == 0) return 0;
      if (r >= h) return Q_ONE;
      num = r;
      num = (num << 30) / h;
      t   = num;
      t2  = q30_mul(t, t);
      acc = -longint'(stg_pkg::SC11);
      acc = longint'(stg_pkg::SC9) + q30_mul(acc, t2);
      acc = -longint'(stg_pkg::SC7) + q30_mul(acc, t2);
      acc = longint'(stg_pkg::SC5) + q30_mul(acc, t2);
      acc = -longint'(stg_pkg::SC3) + q30_mul(acc, t2);
      acc = longint'(stg_pkg::SC1) + q30_mul(acc, t2);
      acc = q30_mul(acc, t);
      if (acc < 0) acc = 0;
      if (acc > Q_ONE) acc = Q_ONE;
      return acc;
   endfunction

   // sample value for one index under the current register shadow
   function automatic logic [stg_pkg::VAL_W-1:0] sine_sample(
      input logic [stg_pkg::IDX_W-1:0] idx);
      int unsigned per, h, k, m, r, ix, ph;
      bit neg;
      longint unsigned s, prod, mag;
      per = period_cfg;
      ix  = idx;
      ph  = phase_cfg;
      if (per < 2) per = 2;                     // short period acts as 2
      if (per > stg_pkg::MAX_POINTS_DEF) per = stg_pkg::MAX_POINTS_DEF;
      h   = per / 2;
      k   = peak_cfg / 2;
      m   = (ix + ph) % (2 * h);
      neg = (m >= h);
      if (neg) m = m - h;
      r = 2 * m;
      if (r > h) r = 2 * h - r;                 // fold into first quadrant
      s    = quarter_wave(r, h);
      prod = k * s;
      if (neg) begin
         mag = (prod + Q_ONE - 1) >> 30;        // ceil when subtracting
         return stg_pkg::VAL_W'(k - mag);
      end else begin
         mag = prod >> 30;
         return stg_pkg::VAL_W'(k + mag);
      end
   endfunction

   // ------------------------------------------------------------------------
   // Request side
   // ------------------------------------------------------------------------

   // offer one request; sender runs in bursts with random gaps between them
   task automatic offer_sample(input logic [stg_pkg::IDX_W-1:0] idx, input bit typed,
                               input logic [stg_pkg::VAL_W-1:0] golden);
      int gap;
      sample_type want;
      @(negedge clock);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata  <= idx;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      want.idx   = idx;
      want.value = typed ? golden : sine_sample(idx);
      pending_samples.push_back(want);
   endtask

   // stop offering and let the pipe run dry
   task automatic drain_pipe();
      @(negedge clock);
      req_tvalid <= 1'b0;
      burst_left = 0;
      while (pending_samples.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(input logic [stg_pkg::CSR_ADDR_W-1:0] addr,
                            input logic [stg_pkg::CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= addr;
      csr_wdata <= data;
      @(negedge clock);
      csr_we    <= 1'b0;
      case (addr)
         stg_pkg::CSR_PERIOD: period_cfg = data[stg_pkg::PER_W-1:0];
         stg_pkg::CSR_PEAK:   peak_cfg   = data[stg_pkg::PEAK_W-1:0];
         stg_pkg::CSR_PHASE:  phase_cfg  = data[stg_pkg::PHASE_W-1:0];
         default: ;                             // unknown index: ignored
      endcase
   endtask

   task automatic add_row(input row_kind_type kind,
                          input logic [stg_pkg::CSR_ADDR_W-1:0] addr,
                          input logic [stg_pkg::CSR_DATA_W-1:0] data,
                          input logic [stg_pkg::IDX_W-1:0] idx,
                          input logic [stg_pkg::VAL_W-1:0] golden);
      stim_row_type row;
      row.kind   = kind;
      row.addr   = addr;
      row.data   = data;
      row.idx    = idx;
      row.golden = golden;
      stim_rows.push_back(row);
   endtask

   // ------------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------------
   initial begin
      logic [stg_pkg::CSR_DATA_W-1:0] per_val, peak_val, phase_val;
      bit last_csr;

      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      csr_we     = 1'b0;
      csr_addr   = '0;
      csr_wdata  = '0;
      period_cfg = stg_pkg::PER_W'(stg_pkg::PERIOD_RST);
      peak_cfg   = stg_pkg::PEAK_W'(stg_pkg::PEAK_RST);
      phase_cfg  = '0;
      fail_count = 0;
      burst_left = 0;
      hold_asked = 0;
      hold_served = 0;

      // reset values: period 64 (H = 32), peak 800 (K = 400), phase 0
      add_row(ROW_REQ_CHK, stg_pkg::CSR_PERIOD, '0, 8'd0,   16'd400);  // zero crossing
      add_row(ROW_REQ_CHK, stg_pkg::CSR_PERIOD, '0, 8'd16,  16'd800);  // positive crest
      add_row(ROW_REQ_CHK, stg_pkg::CSR_PERIOD, '0, 8'd32,  16'd400);  // half-period
      add_row(ROW_REQ_CHK, stg_pkg::CSR_PERIOD, '0, 8'd48,  16'd0);    // negative crest
      add_row(ROW_REQ,     stg_pkg::CSR_PERIOD, '0, 8'd255, '0);
      add_row(ROW_REQ,     stg_pkg::CSR_PERIOD, '0, 8'd200, '0);
      // short period: 0 and 1 both behave as 2
      add_row(ROW_CSR,     stg_pkg::CSR_PERIOD, 16'd0, '0, '0);
      add_row(ROW_REQ_CHK, stg_pkg::CSR_PERIOD, '0, 8'd0,   16'd400);
      add_row(ROW_REQ_CHK, stg_pkg::CSR_PERIOD, '0, 8'd1,   16'd400);
      add_row(ROW_CSR,     stg_pkg::CSR_PERIOD, 16'd1, '0, '0);
      add_row(ROW_REQ_CHK, stg_pkg::CSR_PERIOD, '0, 8'd255, 16'd400);
      // long period saturates to 256; full-scale peak; crests via phase 64
      add_row(ROW_CSR,     stg_pkg::CSR_PERIOD, 16'd511, '0, '0);
      add_row(ROW_CSR,     stg_pkg::CSR_PEAK,   16'hFFFF, '0, '0);
      add_row(ROW_CSR,     stg_pkg::CSR_PHASE,  16'd64, '0, '0);
      add_row(ROW_REQ_CHK, stg_pkg::CSR_PERIOD, '0, 8'd0,   16'd65534);
      add_row(ROW_REQ_CHK, stg_pkg::CSR_PERIOD, '0, 8'd128, 16'd0);
      add_row(ROW_REQ,     stg_pkg::CSR_PERIOD, '0, 8'd37,  '0);
      // largest phase offset
      add_row(ROW_CSR,     stg_pkg::CSR_PHASE,  16'd1023, '0, '0);
      add_row(ROW_REQ,     stg_pkg::CSR_PERIOD, '0, 8'd255, '0);
      add_row(ROW_REQ,     stg_pkg::CSR_PERIOD, '0, 8'd0,   '0);
      // zero and one peak: K = 0 gives a flat zero
      add_row(ROW_CSR,     stg_pkg::CSR_PEAK,   16'd0, '0, '0);
      add_row(ROW_REQ_CHK, stg_pkg::CSR_PERIOD, '0, 8'd37,  16'd0);
      add_row(ROW_CSR,     stg_pkg::CSR_PEAK,   16'd1, '0, '0);
      add_row(ROW_REQ_CHK, stg_pkg::CSR_PERIOD, '0, 8'd200, 16'd0);
      // odd period 7 acts as 6, odd peak 7 gives K = 3
      add_row(ROW_CSR,     stg_pkg::CSR_PERIOD, 16'd7, '0, '0);
      add_row(ROW_CSR,     stg_pkg::CSR_PEAK,   16'd7, '0, '0);
      add_row(ROW_CSR,     stg_pkg::CSR_PHASE,  16'd0, '0, '0);
      add_row(ROW_REQ_CHK, stg_pkg::CSR_PERIOD, '0, 8'd0,   16'd3);
      add_row(ROW_REQ_CHK, stg_pkg::CSR_PERIOD, '0, 8'd3,   16'd3);
      add_row(ROW_REQ,     stg_pkg::CSR_PERIOD, '0, 8'd5,   '0);
      add_row(ROW_REQ,     stg_pkg::CSR_PERIOD, '0, 8'd1,   '0);
      // write to an unknown index must change nothing
      add_row(ROW_CSR,     CSR_UNUSED,          16'hFFFF, '0, '0);
      add_row(ROW_REQ,     stg_pkg::CSR_PERIOD, '0, 8'd2,   '0);
      add_row(ROW_REQ,     stg_pkg::CSR_PERIOD, '0, 8'd4,   '0);

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed part; registers only move once the pipe is empty
      last_csr = 1'b0;
      foreach (stim_rows[i]) begin
         if (stim_rows[i].kind == ROW_CSR) begin
            if (!last_csr) drain_pipe();
            write_csr(stim_rows[i].addr, stim_rows[i].data);
            last_csr = 1'b1;
         end else begin
            offer_sample(stim_rows[i].idx, stim_rows[i].kind == ROW_REQ_CHK,
                         stim_rows[i].golden);
            last_csr = 1'b0;
         end
      end

      // random part: one register setting per phase, extremes favored
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         drain_pipe();
         case ($urandom_range(0, 7))
            0: per_val = 16'd0;
            1: per_val = 16'd2;
            2: per_val = 16'd511;
            3: per_val = 16'd256;
            4: per_val = 16'($urandom_range(257, 511));
            5: per_val = 16'($urandom_range(3, 32));
            default: per_val = 16'($urandom_range(0, 511));
         endcase
         case ($urandom_range(0, 5))
            0: peak_val = 16'd0;
            1: peak_val = 16'hFFFF;
            2: peak_val = 16'hFFFE;
            default: peak_val = 16'($urandom_range(0, 65535));
         endcase
         case ($urandom_range(0, 3))
            0: phase_val = 16'd0;
            1: phase_val = 16'd1023;
            default: phase_val = 16'($urandom_range(0, 1023));
         endcase
         write_csr(stg_pkg::CSR_PERIOD, per_val);
         write_csr(stg_pkg::CSR_PEAK, peak_val);
         write_csr(stg_pkg::CSR_PHASE, phase_val);
         if ($urandom_range(0, 3) == 0) write_csr(CSR_UNUSED, 16'($urandom_range(0, 65535)));
         // long receiver hold-off so the pipe and its skid buffer fill up
         if (p == 2 || p == 7) hold_asked++;
         for (int n = 0; n < ITEMS_PER_PHASE; n++)
            offer_sample(8'($urandom_range(0, 255)), 1'b0, '0);
      end

      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_samples.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending_samples.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   // ------------------------------------------------------------------------
   // Response side: ready follows its own stall pattern
   // ------------------------------------------------------------------------
   initial begin
      int mode, stretch;
      rsp_tready = 1'b0;
      stretch    = 0;
      mode       = 0;
      forever begin
         @(negedge clock);
         if (hold_served < hold_asked) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_served++;
         end
         if (stretch == 0) begin
            stretch = $urandom_range(20, 200);
            mode    = $urandom_range(0, 3);
         end
         stretch--;
         case (mode)
            0: rsp_tready <= 1'b1;                              // no stalls
            1: rsp_tready <= ($urandom_range(0, 3) != 0);       // light stalls
            2: rsp_tready <= ($urandom_range(0, 3) == 0);       // heavy stalls
            default: rsp_tready <= stretch[0];                  // alternating ready and stall
         endcase
      end
   end

   // check each accepted response against the oldest expected sample
   always @(posedge clock) begin
      sample_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_samples.size() == 0) begin
            fail_count++;
            if (fail_count <= 10)
               $display("unexpected response: idx %0d value %0d",
                        rsp_tdata[stg_pkg::IDX_W-1:0],
                        rsp_tdata[stg_pkg::IDX_W +: stg_pkg::VAL_W]);
         end else begin
            want = pending_samples.pop_front();
            if (rsp_tdata[stg_pkg::IDX_W-1:0] !== want.idx
                || rsp_tdata[stg_pkg::IDX_W +: stg_pkg::VAL_W] !== want.value) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("mismatch: expected idx %0d value %0d, got idx %0d value %0d",
                           want.idx, want.value,
                           rsp_tdata[stg_pkg::IDX_W-1:0],
                           rsp_tdata[stg_pkg::IDX_W +: stg_pkg::VAL_W]);
            end
         end
      end
   end

endmodule
